FILE: rtl/core/sliscp_pkg.sv
`timescale 1ns / 1ps
// sliscp_pkg: types, step constant ROM and step function of sLiSCP-light-256.
// No dependencies; used by sliscp_light256_permutation_unit.
package sliscp_pkg;

  localparam int WORD_W = 32;
  localparam int NUM_WORDS = 8;
  localparam int CNT_W = 5;
  localparam int ROM_STEPS = 18;
  localparam logic [CNT_W-1:0] STEP_COUNT_RESET = 5'd18;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [CNT_W-1:0] step_cnt_t;

  // Per step: box (2,3) constant, box (6,7) constant, word 1 and word 5 constants
  localparam logic [7:0] STEP_ROM [0:ROM_STEPS*4-1] = '{
    8'h0f, 8'h47, 8'h08, 8'h64, 8'h04, 8'hb2, 8'h86, 8'h6b,
    8'h43, 8'hb5, 8'he2, 8'h6f, 8'hf1, 8'h37, 8'h89, 8'h2c,
    8'h44, 8'h96, 8'he6, 8'hdd, 8'h73, 8'hee, 8'hca, 8'h99,
    8'he5, 8'h4c, 8'h17, 8'hea, 8'h0b, 8'hf5, 8'h8e, 8'h0f,
    8'h47, 8'h07, 8'h64, 8'h04, 8'hb2, 8'h82, 8'h6b, 8'h43,
    8'hb5, 8'ha1, 8'h6f, 8'hf1, 8'h37, 8'h78, 8'h2c, 8'h44,
    8'h96, 8'ha2, 8'hdd, 8'h73, 8'hee, 8'hb9, 8'h99, 8'he5,
    8'h4c, 8'hf2, 8'hea, 8'h0b, 8'hf5, 8'h85, 8'h0f, 8'h47,
    8'h07, 8'h23, 8'h04, 8'hb2, 8'h82, 8'hd9, 8'h43, 8'hb5
  };

  // One Simeck-64 round: b absorbs f(a) and one constant bit
  function automatic logic [WORD_W-1:0] simeck_mix(logic [WORD_W-1:0] a,
                                                   logic [WORD_W-1:0] b,
                                                   logic rc_bit);
    logic [WORD_W-1:0] rot1;
    logic [WORD_W-1:0] rot5;
    rot1 = {a[WORD_W-2:0], a[WORD_W-1]};
    rot5 = {a[WORD_W-6:0], a[WORD_W-1:WORD_W-5]};
    return b ^ rot1 ^ (rot5 & a) ^ {{(WORD_W-1){1'b1}}, rc_bit};
  endfunction

  // One full step: two 8-round boxes, constants, then the Feistel word shuffle
  function automatic state_t sliscp_step(state_t w, logic [7:0] rc_a, logic [7:0] rc_b,
                                         logic [7:0] sc_a, logic [7:0] sc_b);
    state_t o;
    logic [WORD_W-1:0] l0;
    logic [WORD_W-1:0] r0;
    logic [WORD_W-1:0] l1;
    logic [WORD_W-1:0] r1;
    l0 = w[2];
    r0 = w[3];
    l1 = w[6];
    r1 = w[7];
    for (int i = 0; i < 4; i++) begin
      r0 = simeck_mix(l0, r0, rc_a[2*i]);
      l0 = simeck_mix(r0, l0, rc_a[2*i+1]);
      r1 = simeck_mix(l1, r1, rc_b[2*i]);
      l1 = simeck_mix(r1, l1, rc_b[2*i+1]);
    end
    o[0] = l0;
    o[1] = r0;
    o[2] = ~w[4] ^ l1;
    o[3] = w[5] ^ {24'hFFFFFF, sc_b} ^ r1;
    o[4] = l1;
    o[5] = r1;
    o[6] = ~w[0] ^ l0;
    o[7] = w[1] ^ {24'hFFFFFF, sc_a} ^ r0;
    return o;
  endfunction

endpackage

FILE: rtl/core/sliscp_light256_permutation_unit.sv
`timescale 1ns / 1ps
// sliscp_light256_permutation_unit: fully unrolled sLiSCP-light-256 step pipeline.
// Depends on sliscp_pkg (state type, step ROM, step function).
//
//  channel | direction | handshake              | word
//  in_     | input     | in_valid / in_ready    | 8 x 32-bit state
//  out_    | output    | out_valid / out_ready  | 8 x 32-bit permuted state
//  cfg_    | input     | cfg_valid / cfg_ready  | 5-bit step count
//
// One word accepted per cycle unless a stall backs up to the input; one register
// per step plus the input register. Each step stage applies its step only when the
// word's saturated step count is at least the stage number. Synchronous active-low
// reset clears valid bits and sets step count to 18. A stall holds each full
// stage whose successor cannot take a word; empty stages keep filling.
module sliscp_light256_permutation_unit
  import sliscp_pkg::*;
#(
  parameter int MAX_STEPS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WORD_W-1:0]   in_word0,
  input  logic [WORD_W-1:0]   in_word1,
  input  logic [WORD_W-1:0]   in_word2,
  input  logic [WORD_W-1:0]   in_word3,
  input  logic [WORD_W-1:0]   in_word4,
  input  logic [WORD_W-1:0]   in_word5,
  input  logic [WORD_W-1:0]   in_word6,
  input  logic [WORD_W-1:0]   in_word7,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_word0,
  output logic [WORD_W-1:0]   out_word1,
  output logic [WORD_W-1:0]   out_word2,
  output logic [WORD_W-1:0]   out_word3,
  output logic [WORD_W-1:0]   out_word4,
  output logic [WORD_W-1:0]   out_word5,
  output logic [WORD_W-1:0]   out_word6,
  output logic [WORD_W-1:0]   out_word7
);

  localparam step_cnt_t MAX_CNT = CNT_W'(MAX_STEPS);

  step_cnt_t step_cnt_r;
  step_cnt_t step_sat;
  state_t    in_state;

  state_t    stage_r   [0:MAX_STEPS];
  step_cnt_t cnt_r     [0:MAX_STEPS];
  logic      valid_r   [0:MAX_STEPS];
  logic      stage_rdy [0:MAX_STEPS];

  // Step count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= STEP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_cnt_r <= cfg_data;
    end
  end

  assign step_sat = (step_cnt_r > MAX_CNT) ? MAX_CNT : step_cnt_r;

  assign in_state = {in_word7, in_word6, in_word5, in_word4,
                     in_word3, in_word2, in_word1, in_word0};

  // Ready chain: a stage takes a word when empty or when it drains
  assign stage_rdy[MAX_STEPS] = !valid_r[MAX_STEPS] || out_ready;

  genvar k;
  generate
    for (k = 0; k < MAX_STEPS; k++) begin : g_rdy
      assign stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    end
  endgenerate

  assign in_ready = stage_rdy[0];

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (stage_rdy[0]) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[0] && in_valid) begin
      stage_r[0] <= in_state;
      cnt_r[0]   <= step_sat;
    end
  end

  // Step stages, one permutation step each
  generate
    for (k = 1; k <= MAX_STEPS; k++) begin : g_step
      state_t stepped;

      assign stepped = sliscp_step(stage_r[k-1],
                                   STEP_ROM[4*(k-1)], STEP_ROM[4*(k-1)+1],
                                   STEP_ROM[4*(k-1)+2], STEP_ROM[4*(k-1)+3]);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (stage_rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (stage_rdy[k] && valid_r[k-1]) begin
          stage_r[k] <= (cnt_r[k-1] > CNT_W'(k-1)) ? stepped : stage_r[k-1];
          cnt_r[k]   <= cnt_r[k-1];
        end
      end
    end
  endgenerate

  // Result
  assign out_valid = valid_r[MAX_STEPS];
  assign out_word0 = stage_r[MAX_STEPS][0];
  assign out_word1 = stage_r[MAX_STEPS][1];
  assign out_word2 = stage_r[MAX_STEPS][2];
  assign out_word3 = stage_r[MAX_STEPS][3];
  assign out_word4 = stage_r[MAX_STEPS][4];
  assign out_word5 = stage_r[MAX_STEPS][5];
  assign out_word6 = stage_r[MAX_STEPS][6];
  assign out_word7 = stage_r[MAX_STEPS][7];

`ifndef SYNTHESIS
  // accepted word lands in the input register with a saturated count
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0] && cnt_r[0] <= MAX_CNT)
    else $error("input word not captured with saturated count");

  // a stalled input stage holds its word
  a_stage0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && !stage_rdy[0] |=> valid_r[0] && $stable(stage_r[0]))
    else $error("stalled input stage lost its word");

  // a word in the second-to-last stage moves on when the last stage can take it
  a_last_advance: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[MAX_STEPS-1] && stage_rdy[MAX_STEPS] |=> valid_r[MAX_STEPS])
    else $error("word dropped before output stage");

  // saturated count never exceeds the pipeline depth
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_sat <= MAX_CNT)
    else $error("step count saturation failed");
`endif

endmodule
